FILE: hdl/ngga_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// ngga_pkg
// Shared types and constants of the GGA position parser: character codes,
// the classified byte passed from front to back, the parse steps, the result
// record and the status groups watched by the top level.
// ============================================================================
package ngga_pkg;

    // ascii codes the parser tests for
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    // queue depth between stages and at the result side
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);

    // one received byte with its character class flags
    typedef struct packed {
        logic [7:0] data;
        logic       is_g;
        logic       is_a;
        logic       is_comma;
        logic       is_point;
        logic       is_s;
        logic       is_e;
    } ngga_item_t;

    // parse steps through the sentence
    typedef enum logic [4:0] {
        ST_HUNT_G1       = 5'd1,
        ST_HUNT_G2       = 5'd2,
        ST_HUNT_A        = 5'd3,
        ST_SKIP_TIME     = 5'd4,
        ST_SKIP_TO_LAT   = 5'd5,
        ST_LAT_DEG       = 5'd6,
        ST_LAT_MIN_TENS  = 5'd7,
        ST_LAT_MIN_UNITS = 5'd8,
        ST_LAT_INT       = 5'd9,
        ST_LAT_FRAC0     = 5'd10,
        ST_LAT_FRAC1     = 5'd11,
        ST_LAT_FRAC2     = 5'd12,
        ST_LAT_FRAC3     = 5'd13,
        ST_LAT_HEMI      = 5'd14,
        ST_LAT_SKIP      = 5'd15,
        ST_LON_DEG       = 5'd16,
        ST_LON_MIN_TENS  = 5'd17,
        ST_LON_MIN_UNITS = 5'd18,
        ST_LON_INT       = 5'd19,
        ST_LON_FRAC0     = 5'd20,
        ST_LON_FRAC1     = 5'd21,
        ST_LON_FRAC2     = 5'd22,
        ST_LON_FRAC3     = 5'd23,
        ST_LON_HEMI      = 5'd24,
        ST_LON_SKIP      = 5'd25,
        ST_SKIP_FIELD1   = 5'd26,
        ST_SKIP_FIELD2   = 5'd27,
        ST_SKIP_FIELD3   = 5'd28,
        ST_HEIGHT        = 5'd29,
        ST_TENTHS        = 5'd30
    } ngga_step_t;

    // one completed sentence
    typedef struct packed {
        logic [23:0] lat_degree_digits;
        logic [15:0] lat_minute_digits;
        logic [31:0] lat_fraction_digits;
        logic        lat_south;
        logic [23:0] lon_degree_digits;
        logic [15:0] lon_minute_digits;
        logic [31:0] lon_fraction_digits;
        logic        lon_west;
        logic [39:0] height_digits;
        logic [7:0]  height_tenths_digit;
        logic        fix_indicator;
    } ngga_result_t;

    // front queue status
    typedef struct packed {
        logic [CNT_W-1:0] count;
    } ngga_front_status_t;

    // back status
    typedef struct packed {
        logic             res_write;
        logic             fix_level;
        logic [CNT_W-1:0] res_count;
    } ngga_back_status_t;

endpackage

FILE: hdl/nmea_gga_position_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Takes one received character per clock while the front queue is not full
// and parses a GGA sentence into ASCII latitude, longitude and height
// digits. A front queue of two entries holds the classified bytes and the
// parse state machine takes one per cycle as long as the two-entry result
// queue has room. A result is written into the result queue when its
// tenths-of-meter byte is accepted and shows on the output ports once it
// heads that queue, and the fix indicator toggles with each completed
// sentence. Both queues stall on their own, so a waiting result does not
// hold up the input side until both result entries are occupied.
// ----------------------------------------------------------------------------
// ============================================================================
// nmea_gga_position_parser
// Top level: byte classifier front, parse back end and result queue.
// ============================================================================
module nmea_gga_position_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    input  logic        pop,
    output logic        empty,
    output logic [23:0] lat_degree_digits,
    output logic [15:0] lat_minute_digits,
    output logic [31:0] lat_fraction_digits,
    output logic        lat_south,
    output logic [23:0] lon_degree_digits,
    output logic [15:0] lon_minute_digits,
    output logic [31:0] lon_fraction_digits,
    output logic        lon_west,
    output logic [39:0] height_digits,
    output logic [7:0]  height_tenths_digit,
    output logic        fix_indicator
);
    import ngga_pkg::*;

    logic               item_valid;
    logic               item_ready;
    ngga_item_t         item;
    ngga_result_t       result;
    ngga_front_status_t front_status;
    ngga_back_status_t  back_status;

    // byte classifier and queue
    ngga_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .rx_byte    (rx_byte),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .status     (front_status)
    );

    // parse state machine and result queue
    ngga_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .empty      (empty),
        .pop        (pop),
        .result     (result),
        .status     (back_status)
    );

    // result fields to ports
    assign lat_degree_digits   = result.lat_degree_digits;
    assign lat_minute_digits   = result.lat_minute_digits;
    assign lat_fraction_digits = result.lat_fraction_digits;
    assign lat_south           = result.lat_south;
    assign lon_degree_digits   = result.lon_degree_digits;
    assign lon_minute_digits   = result.lon_minute_digits;
    assign lon_fraction_digits = result.lon_fraction_digits;
    assign lon_west            = result.lon_west;
    assign height_digits       = result.height_digits;
    assign height_tenths_digit = result.height_tenths_digit;
    assign fix_indicator       = result.fix_indicator;

    // each completed sentence toggles the fix level
    a_fix_toggle : assert property (@(posedge clk) disable iff (!rst_n)
        back_status.res_write |=> (back_status.fix_level != $past(back_status.fix_level)))
        else $error("fix level did not toggle on a completed sentence");

    // fix level holds between sentences
    a_fix_hold : assert property (@(posedge clk) disable iff (!rst_n)
        !back_status.res_write |=> $stable(back_status.fix_level))
        else $error("fix level changed without a completed sentence");

    // queues never overfill
    a_front_bound : assert property (@(posedge clk) disable iff (!rst_n)
        front_status.count <= CNT_W'(QUEUE_DEPTH))
        else $error("front queue overfilled");

    a_back_bound : assert property (@(posedge clk) disable iff (!rst_n)
        back_status.res_count <= CNT_W'(QUEUE_DEPTH))
        else $error("result queue overfilled");

    // a result is only written while a byte is handed over
    a_write_take : assert property (@(posedge clk) disable iff (!rst_n)
        back_status.res_write |-> (item_valid && item_ready))
        else $error("result written without a byte transaction");

endmodule

FILE: hdl/ngga_front.sv
`timescale 1ns / 1ps
// ============================================================================
// ngga_front
// Accepts received bytes, tags each with its character class and holds them
// in a short queue until the parse stage takes them.
// ============================================================================
module ngga_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [7:0]                  rx_byte,
    output logic                        item_valid,
    input  logic                        item_ready,
    output ngga_pkg::ngga_item_t        item,
    output ngga_pkg::ngga_front_status_t status
);
    import ngga_pkg::*;

    ngga_item_t       mem_reg [QUEUE_DEPTH];
    ngga_item_t       class_item;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             wr_en;
    logic             rd_en;

    // classify the incoming byte
    always_comb
    begin
        class_item.data     = rx_byte;
        class_item.is_g     = (rx_byte == CH_G);
        class_item.is_a     = (rx_byte == CH_A);
        class_item.is_comma = (rx_byte == CH_COMMA);
        class_item.is_point = (rx_byte == CH_POINT);
        class_item.is_s     = (rx_byte == CH_S);
        class_item.is_e     = (rx_byte == CH_E);
    end

    // handshakes
    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign item_valid = (count_reg != '0);
    assign wr_en      = push && !full;
    assign rd_en      = item_valid && item_ready;
    assign item       = mem_reg[rd_ptr_reg];
    assign status.count = count_reg;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // queue control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= class_item;
        end
    end

endmodule

FILE: hdl/ngga_back.sv
`timescale 1ns / 1ps
// ============================================================================
// ngga_back
// Walks the GGA parse steps over classified bytes, keeps the digit stores
// and places each completed sentence into a short result queue.
// ============================================================================
module ngga_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  ngga_pkg::ngga_item_t        item,
    output logic                        empty,
    input  logic                        pop,
    output ngga_pkg::ngga_result_t      result,
    output ngga_pkg::ngga_back_status_t status
);
    import ngga_pkg::*;

    ngga_step_t  state_reg;
    ngga_step_t  state_next;
    logic [23:0] lat_deg_reg;
    logic [23:0] lat_deg_next;
    logic [15:0] lat_min_reg;
    logic [15:0] lat_min_next;
    logic [31:0] lat_frac_reg;
    logic [31:0] lat_frac_next;
    logic        lat_sign_reg;
    logic        lat_sign_next;
    logic [23:0] lon_deg_reg;
    logic [23:0] lon_deg_next;
    logic [15:0] lon_min_reg;
    logic [15:0] lon_min_next;
    logic [31:0] lon_frac_reg;
    logic [31:0] lon_frac_next;
    logic        lon_sign_reg;
    logic        lon_sign_next;
    logic [39:0] height_reg;
    logic [39:0] height_next;
    logic        level_reg;
    logic        level_next;
    logic        take;
    logic        res_write;
    ngga_result_t res_data;

    ngga_result_t     res_mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] res_wr_reg;
    logic [PTR_W-1:0] res_wr_next;
    logic [PTR_W-1:0] res_rd_reg;
    logic [PTR_W-1:0] res_rd_next;
    logic [CNT_W-1:0] res_count_reg;
    logic [CNT_W-1:0] res_count_next;
    logic             res_read;

    // take a byte whenever the result queue has room
    assign item_ready = (res_count_reg != CNT_W'(QUEUE_DEPTH));
    assign take       = item_valid && item_ready;

    // parse steps and digit stores
    always_comb
    begin
        state_next    = state_reg;
        lat_deg_next  = lat_deg_reg;
        lat_min_next  = lat_min_reg;
        lat_frac_next = lat_frac_reg;
        lat_sign_next = lat_sign_reg;
        lon_deg_next  = lon_deg_reg;
        lon_min_next  = lon_min_reg;
        lon_frac_next = lon_frac_reg;
        lon_sign_next = lon_sign_reg;
        height_next   = height_reg;
        level_next    = level_reg;
        res_write     = 1'b0;
        if (take)
        begin
            unique case (state_reg)
                ST_HUNT_G1:
                begin
                    if (item.is_g)
                    begin
                        state_next = ST_HUNT_G2;
                    end
                end
                ST_HUNT_G2:
                begin
                    state_next = item.is_g ? ST_HUNT_A : ST_HUNT_G1;
                end
                ST_HUNT_A:
                begin
                    state_next = item.is_a ? ST_SKIP_TIME : ST_HUNT_G1;
                end
                ST_SKIP_TIME:
                begin
                    if (item.is_comma)
                    begin
                        state_next = ST_SKIP_TO_LAT;
                    end
                end
                ST_SKIP_TO_LAT:
                begin
                    if (item.is_comma)
                    begin
                        state_next = ST_LAT_DEG;
                    end
                end
                ST_LAT_DEG:
                begin
                    lat_deg_next = {CH_ZERO, CH_ZERO, item.data};
                    state_next   = ST_LAT_MIN_TENS;
                end
                ST_LAT_MIN_TENS:
                begin
                    lat_min_next = {item.data, lat_min_reg[7:0]};
                    state_next   = ST_LAT_MIN_UNITS;
                end
                ST_LAT_MIN_UNITS:
                begin
                    lat_min_next = {lat_min_reg[15:8], item.data};
                    state_next   = ST_LAT_INT;
                end
                ST_LAT_INT:
                begin
                    if (item.is_point)
                    begin
                        lat_frac_next = {4{CH_ZERO}};
                        state_next    = ST_LAT_FRAC0;
                    end
                    else
                    begin
                        // extra integer digit shifts the oldest one out
                        lat_deg_next = {lat_deg_reg[15:0], lat_min_reg[15:8]};
                        lat_min_next = {lat_min_reg[7:0], item.data};
                    end
                end
                ST_LAT_FRAC0:
                begin
                    lat_frac_next = {item.data, lat_frac_reg[23:0]};
                    state_next    = ST_LAT_FRAC1;
                end
                ST_LAT_FRAC1:
                begin
                    if (item.is_comma)
                    begin
                        state_next = ST_LAT_HEMI;
                    end
                    else
                    begin
                        lat_frac_next = {lat_frac_reg[31:24], item.data, lat_frac_reg[15:0]};
                        state_next    = ST_LAT_FRAC2;
                    end
                end
                ST_LAT_FRAC2:
                begin
                    if (item.is_comma)
                    begin
                        state_next = ST_LAT_HEMI;
                    end
                    else
                    begin
                        lat_frac_next = {lat_frac_reg[31:16], item.data, lat_frac_reg[7:0]};
                        state_next    = ST_LAT_FRAC3;
                    end
                end
                ST_LAT_FRAC3:
                begin
                    if (item.is_comma)
                    begin
                        state_next = ST_LAT_HEMI;
                    end
                    else
                    begin
                        lat_frac_next = {lat_frac_reg[31:8], item.data};
                        state_next    = ST_LAT_HEMI;
                    end
                end
                ST_LAT_HEMI:
                begin
                    lat_sign_next = item.is_s;
                    state_next    = ST_LAT_SKIP;
                end
                ST_LAT_SKIP:
                begin
                    state_next = ST_LON_DEG;
                end
                ST_LON_DEG:
                begin
                    lon_deg_next = {CH_ZERO, CH_ZERO, item.data};
                    state_next   = ST_LON_MIN_TENS;
                end
                ST_LON_MIN_TENS:
                begin
                    lon_min_next = {item.data, lon_min_reg[7:0]};
                    state_next   = ST_LON_MIN_UNITS;
                end
                ST_LON_MIN_UNITS:
                begin
                    lon_min_next = {lon_min_reg[15:8], item.data};
                    state_next   = ST_LON_INT;
                end
                ST_LON_INT:
                begin
                    if (item.is_point)
                    begin
                        lon_frac_next = {4{CH_ZERO}};
                        state_next    = ST_LON_FRAC0;
                    end
                    else
                    begin
                        lon_deg_next = {lon_deg_reg[15:0], lon_min_reg[15:8]};
                        lon_min_next = {lon_min_reg[7:0], item.data};
                    end
                end
                ST_LON_FRAC0:
                begin
                    lon_frac_next = {item.data, lon_frac_reg[23:0]};
                    state_next    = ST_LON_FRAC1;
                end
                ST_LON_FRAC1:
                begin
                    if (item.is_comma)
                    begin
                        state_next = ST_LON_HEMI;
                    end
                    else
                    begin
                        lon_frac_next = {lon_frac_reg[31:24], item.data, lon_frac_reg[15:0]};
                        state_next    = ST_LON_FRAC2;
                    end
                end
                ST_LON_FRAC2:
                begin
                    if (item.is_comma)
                    begin
                        state_next = ST_LON_HEMI;
                    end
                    else
                    begin
                        lon_frac_next = {lon_frac_reg[31:16], item.data, lon_frac_reg[7:0]};
                        state_next    = ST_LON_FRAC3;
                    end
                end
                ST_LON_FRAC3:
                begin
                    if (item.is_comma)
                    begin
                        state_next = ST_LON_HEMI;
                    end
                    else
                    begin
                        lon_frac_next = {lon_frac_reg[31:8], item.data};
                        state_next    = ST_LON_HEMI;
                    end
                end
                ST_LON_HEMI:
                begin
                    lon_sign_next = !item.is_e;
                    state_next    = ST_LON_SKIP;
                end
                ST_LON_SKIP:
                begin
                    state_next = ST_SKIP_FIELD1;
                end
                ST_SKIP_FIELD1:
                begin
                    if (item.is_comma)
                    begin
                        state_next = ST_SKIP_FIELD2;
                    end
                end
                ST_SKIP_FIELD2:
                begin
                    if (item.is_comma)
                    begin
                        state_next = ST_SKIP_FIELD3;
                    end
                end
                ST_SKIP_FIELD3:
                begin
                    if (item.is_comma)
                    begin
                        height_next = {5{CH_ZERO}};
                        state_next  = ST_HEIGHT;
                    end
                end
                ST_HEIGHT:
                begin
                    if (item.is_point)
                    begin
                        state_next = ST_TENTHS;
                    end
                    else
                    begin
                        height_next = {height_reg[31:0], item.data};
                    end
                end
                ST_TENTHS:
                begin
                    level_next = !level_reg;
                    res_write  = 1'b1;
                    state_next = ST_HUNT_G1;
                end
                default:
                begin
                    state_next = ST_HUNT_G1;
                end
            endcase
        end
    end

    // result record built from the stores and the tenths byte
    always_comb
    begin
        res_data.lat_degree_digits   = lat_deg_reg;
        res_data.lat_minute_digits   = lat_min_reg;
        res_data.lat_fraction_digits = lat_frac_reg;
        res_data.lat_south           = lat_sign_reg;
        res_data.lon_degree_digits   = lon_deg_reg;
        res_data.lon_minute_digits   = lon_min_reg;
        res_data.lon_fraction_digits = lon_frac_reg;
        res_data.lon_west            = lon_sign_reg;
        res_data.height_digits       = height_reg;
        res_data.height_tenths_digit = item.data;
        res_data.fix_indicator       = !level_reg;
    end

    // parser registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_HUNT_G1;
            lat_deg_reg  <= '0;
            lat_min_reg  <= '0;
            lat_frac_reg <= '0;
            lat_sign_reg <= 1'b0;
            lon_deg_reg  <= '0;
            lon_min_reg  <= '0;
            lon_frac_reg <= '0;
            lon_sign_reg <= 1'b0;
            height_reg   <= '0;
            level_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            lat_deg_reg  <= lat_deg_next;
            lat_min_reg  <= lat_min_next;
            lat_frac_reg <= lat_frac_next;
            lat_sign_reg <= lat_sign_next;
            lon_deg_reg  <= lon_deg_next;
            lon_min_reg  <= lon_min_next;
            lon_frac_reg <= lon_frac_next;
            lon_sign_reg <= lon_sign_next;
            height_reg   <= height_next;
            level_reg    <= level_next;
        end
    end

    // result queue handshakes
    assign empty    = (res_count_reg == '0);
    assign res_read = pop && !empty;
    assign result   = res_mem_reg[res_rd_reg];

    // result queue pointers and count
    always_comb
    begin
        res_wr_next    = res_wr_reg;
        res_rd_next    = res_rd_reg;
        res_count_next = res_count_reg;
        if (res_write)
        begin
            res_wr_next = (res_wr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : res_wr_reg + 1'b1;
        end
        if (res_read)
        begin
            res_rd_next = (res_rd_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : res_rd_reg + 1'b1;
        end
        if (res_write && !res_read)
        begin
            res_count_next = res_count_reg + 1'b1;
        end
        else if (res_read && !res_write)
        begin
            res_count_next = res_count_reg - 1'b1;
        end
    end

    // result queue control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_reg    <= '0;
            res_rd_reg    <= '0;
            res_count_reg <= '0;
        end
        else
        begin
            res_wr_reg    <= res_wr_next;
            res_rd_reg    <= res_rd_next;
            res_count_reg <= res_count_next;
        end
    end

    // result queue storage
    always_ff @(posedge clk)
    begin
        if (res_write)
        begin
            res_mem_reg[res_wr_reg] <= res_data;
        end
    end

    // status toward the top level
    assign status.res_write = res_write;
    assign status.fix_level = level_reg;
    assign status.res_count = res_count_reg;

endmodule
